/* rtl/core/stt_pkg.sv */
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and character class helpers for the source tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_NUM     = 2'd1,
        MODE_IDENT   = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    localparam logic [1:0] EV_CHAR       = 2'd0;
    localparam logic [1:0] EV_END        = 2'd1;
    localparam logic [1:0] EV_DISCARD    = 2'd2;
    localparam logic [1:0] EV_STREAM_END = 2'd3;

    localparam logic [1:0] CLS_NUM    = 2'd0;
    localparam logic [1:0] CLS_IDENT  = 2'd1;
    localparam logic [1:0] CLS_SINGLE = 2'd2;

    localparam logic [7:0] CH_NEWLINE    = 8'd10;
    localparam logic [7:0] CH_SLASH      = 8'd47;
    localparam logic [7:0] CH_DOT        = 8'd46;
    localparam logic [7:0] CH_UNDERSCORE = 8'd95;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        mode_t       mode;
        logic [15:0] line;
        logic [15:0] col;
        logic [7:0]  len;
        logic        ovf;
    } scan_state_t;

    typedef struct packed {
        logic [1:0]  ev;
        logic [7:0]  ch;
        logic [1:0]  cls;
        logic        starts;
        logic        ends;
        logic [15:0] line;
        logic [15:0] col;
        logic        ovf;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [FIFO_CNT_W-1:0] count;
        logic                  empty;
        logic                  room_for_two;
    } fifo_stat_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/stt_scan.sv */
// ----------------------------------------------------------------------------
// stt_scan
// Per-character scanner: next scan state and up to two results for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_scan
    import stt_pkg::*;
(
    input  scan_state_t st,
    input  logic [7:0]  char_code,
    input  logic        end_of_input,
    input  logic [7:0]  max_len,
    output scan_state_t st_next,
    output result_t     res0,
    output result_t     res1,
    output logic [1:0]  res_cnt
);

    logic [15:0] col_inc;
    logic        in_token;
    logic        more;
    logic        keep;
    logic [1:0]  tok_cls;
    logic        fresh_v;
    result_t     fresh_r;

    assign col_inc  = sat_inc16(st.col);
    assign in_token = (st.mode == MODE_NUM) || (st.mode == MODE_IDENT);
    assign tok_cls  = (st.mode == MODE_NUM) ? CLS_NUM : CLS_IDENT;
    assign more     = (st.mode == MODE_NUM)
                    ? (is_digit(char_code) || (char_code == CH_DOT))
                    : (is_alpha(char_code) || is_digit(char_code)
                       || (char_code == CH_UNDERSCORE));
    assign keep     = st.len < max_len;

    // result for a byte taken while between tokens
    always_comb begin
        fresh_r        = '0;
        fresh_v        = !is_space(char_code) && (char_code != CH_SLASH);
        fresh_r.ev     = EV_CHAR;
        fresh_r.ch     = char_code;
        fresh_r.starts = 1'b1;
        fresh_r.line   = st.line;
        fresh_r.col    = col_inc;
        if (is_digit(char_code)) begin
            fresh_r.cls = CLS_NUM;
        end else if (is_alpha(char_code)) begin
            fresh_r.cls = CLS_IDENT;
        end else begin
            fresh_r.cls  = CLS_SINGLE;
            fresh_r.ends = 1'b1;
        end
    end

    // next state
    always_comb begin
        logic do_fresh;
        do_fresh = 1'b0;
        st_next  = st;
        if (end_of_input) begin
            st_next.mode = MODE_IDLE;
            st_next.line = 16'd1;
            st_next.col  = 16'd0;
            st_next.len  = 8'd0;
            st_next.ovf  = 1'b0;
        end else begin
            st_next.col = col_inc;
            case (st.mode)
                MODE_COMMENT: begin
                    if (char_code == CH_NEWLINE) begin
                        st_next.line = sat_inc16(st.line);
                        st_next.col  = 16'd0;
                        st_next.mode = MODE_IDLE;
                    end
                end
                MODE_NUM, MODE_IDENT: begin
                    if (more) begin
                        if (keep) begin
                            st_next.len = st.len + 8'd1;
                        end else begin
                            st_next.ovf = 1'b1;
                        end
                    end else begin
                        st_next.mode = MODE_IDLE;
                        st_next.len  = 8'd0;
                        st_next.ovf  = 1'b0;
                        do_fresh     = 1'b1;
                    end
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase
            if (do_fresh) begin
                if (is_space(char_code)) begin
                    if (char_code == CH_NEWLINE) begin
                        st_next.line = sat_inc16(st.line);
                        st_next.col  = 16'd0;
                    end
                end else if (char_code == CH_SLASH) begin
                    st_next.mode = MODE_COMMENT;
                end else if (is_digit(char_code)) begin
                    st_next.mode = MODE_NUM;
                    st_next.len  = 8'd1;
                    st_next.ovf  = 1'b0;
                end else if (is_alpha(char_code)) begin
                    st_next.mode = MODE_IDENT;
                    st_next.len  = 8'd1;
                    st_next.ovf  = 1'b0;
                end
            end
        end
    end

    // results
    always_comb begin
        res0    = '0;
        res1    = '0;
        res_cnt = 2'd0;
        if (end_of_input) begin
            if (in_token) begin
                res0.ev   = EV_DISCARD;
                res0.cls  = tok_cls;
                res0.line = st.line;
                res0.col  = col_inc;
                res0.ovf  = st.ovf;
                res1.ev   = EV_STREAM_END;
                res1.line = st.line;
                res1.col  = col_inc;
                res_cnt   = 2'd2;
            end else begin
                res0.ev   = EV_STREAM_END;
                res0.line = st.line;
                res0.col  = col_inc;
                res_cnt   = 2'd1;
            end
        end else begin
            case (st.mode)
                MODE_NUM, MODE_IDENT: begin
                    if (more) begin
                        if (keep) begin
                            res0.ev   = EV_CHAR;
                            res0.ch   = char_code;
                            res0.cls  = tok_cls;
                            res0.line = st.line;
                            res0.col  = col_inc;
                            res_cnt   = 2'd1;
                        end
                    end else begin
                        res0.ev   = EV_END;
                        res0.cls  = tok_cls;
                        res0.line = st.line;
                        res0.col  = col_inc;
                        res0.ovf  = st.ovf;
                        res1      = fresh_r;
                        res_cnt   = fresh_v ? 2'd2 : 2'd1;
                    end
                end
                MODE_IDLE: begin
                    res0    = fresh_r;
                    res_cnt = fresh_v ? 2'd1 : 2'd0;
                end
                default: begin
                    res_cnt = 2'd0;
                end
            endcase
        end
        res0.last = (res_cnt == 2'd1);
        res1.last = (res_cnt == 2'd2);
    end

endmodule

`default_nettype wire

/* rtl/core/stt_res_fifo.sv */
// ----------------------------------------------------------------------------
// stt_res_fifo
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_res_fifo
    import stt_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    input  logic       pop,
    output result_t    head,
    output fifo_stat_t stat
);

    result_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_inc;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;

    assign wr_ptr_inc  = wr_ptr_reg + FIFO_PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
    assign count_next  = count_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr_inc] <= push1;
        end
    end

    assign head              = mem_reg[rd_ptr_reg];
    assign stat.count        = count_reg;
    assign stat.empty        = (count_reg == '0);
    assign stat.room_for_two = (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

/* rtl/core/source_text_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// source_text_tokenizer_core
// Streaming lexer: one source byte per request in, token events out.
// ----------------------------------------------------------------------------
// Results reach the output port through the registered four-entry result
// queue. Throughput: one byte per cycle; the output port moves one result
// per cycle while m_tready is high; a byte with two results (token end plus
// new token) sends both. Input stalls only if the queue lacks two slots.
// Reset (aresetn low, synchronous): scanner idle, line 1, column 0, queue
// empty, max_token_length back to 255.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer_core
    import stt_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: char_code[7:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        s_tlast,   // end_of_input
    // m_tdata: char_out[7:0], starts_token[8], ends_now[9], line_number[25:10],
    //          column_number[41:26], overflowed[42], zero[47:43]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,
    // m_tuser: event_res[1:0], token_class[3:2]
    output logic [3:0]       m_tuser,
    output logic             m_tlast,   // last_of_run
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic REG_MAX_LEN = 1'b0;

    scan_state_t state_reg;
    scan_state_t state_next;
    logic [7:0]  max_len_reg;
    result_t     res0;
    result_t     res1;
    logic [1:0]  res_cnt;
    logic [1:0]  push_cnt;
    logic        s_accept;
    logic        m_accept;
    logic        cfg_write;
    result_t     head;
    fifo_stat_t  fstat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_MAX_LEN) ? {24'd0, max_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 8'd255;
        end else if (cfg_write && (paddr[2] == REG_MAX_LEN)) begin
            max_len_reg <= pwdata[7:0];
        end
    end

    stt_scan u_scan (
        .st           (state_reg),
        .char_code    (s_tdata),
        .end_of_input (s_tlast),
        .max_len      (max_len_reg),
        .st_next      (state_next),
        .res0         (res0),
        .res1         (res1),
        .res_cnt      (res_cnt)
    );

    assign s_tready = fstat.room_for_two;
    assign s_accept = s_tvalid && s_tready;
    assign push_cnt = s_accept ? res_cnt : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode <= MODE_IDLE;
            state_reg.line <= 16'd1;
            state_reg.col  <= 16'd0;
            state_reg.len  <= 8'd0;
            state_reg.ovf  <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    stt_res_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push0    (res0),
        .push1    (res1),
        .pop      (m_accept),
        .head     (head),
        .stat     (fstat)
    );

    assign m_tvalid = !fstat.empty;
    assign m_accept = m_tvalid && m_tready;
    assign m_tdata  = {5'd0, head.ovf, head.col, head.line, head.ends, head.starts, head.ch};
    assign m_tuser  = {head.cls, head.ev};
    assign m_tlast  = head.last;

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fstat.count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue over depth");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (fstat.count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("input ready without room for two results");

    a_eoi_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> (state_reg.mode == MODE_IDLE && state_reg.line == 16'd1
                                   && state_reg.col == 16'd0 && !state_reg.ovf))
        else $error("scanner state not cleared after end of input");

    a_eoi_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |-> (res_cnt != 2'd0))
        else $error("end of input gave no result");

endmodule

`default_nettype wire
